// File: rtl/core/vfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared constants for the voxel face visibility block: chunk size defaults,
// field widths, item codes, and face and suppressed-side bit positions.
// ----------------------------------------------------------------------------
package vfv_pkg;

    localparam int CHUNK_WIDTH_DEF  = 16;
    localparam int CHUNK_LENGTH_DEF = 16;
    localparam int CHUNK_HEIGHT_DEF = 64;

    localparam int X_W    = 4;
    localparam int Y_W    = 6;
    localparam int Z_W    = 4;
    localparam int MASK_W = 6;
    localparam int SUPP_W = 5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // face bit positions in face_mask
    localparam int FACE_FRONT  = 0;
    localparam int FACE_BACK   = 1;
    localparam int FACE_RIGHT  = 2;
    localparam int FACE_LEFT   = 3;
    localparam int FACE_TOP    = 4;
    localparam int FACE_BOTTOM = 5;

    // bit positions in suppressed_sides
    localparam int SUPP_FRONT  = 0;
    localparam int SUPP_BACK   = 1;
    localparam int SUPP_RIGHT  = 2;
    localparam int SUPP_LEFT   = 3;
    localparam int SUPP_BOTTOM = 4;

endpackage
`default_nettype wire

// File: rtl/core/vfv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vfv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/voxel_face_visibility.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Air/solid map of one voxel chunk with face visibility queries.
//
// Input channel (i_in_valid / o_in_stall): a beat with func = write sets one
// voxel's air flag, a beat with func = query asks for the face mask of one
// voxel. Output channel (o_out_valid / i_out_stall): one beat per query,
// carrying face_mask and self_air. Config channel (i_cfg_valid / o_cfg_ready)
// loads suppressed_sides; it is always ready.
// The map sits in a single-port 1-bit RAM. A write goes to the RAM in the
// cycle it is accepted. A query steps through: accept, seven RAM reads
// (self, then the six neighbours, one per cycle through the single port),
// the last read return, and the mask assembly into the output register.
// Throughput is bound by that port: input stays stalled until the query is
// finished. A query outside the chunk skips the RAM reads. After reset a
// clearing pass writes all CHUNK_WIDTH*CHUNK_LENGTH*CHUNK_HEIGHT entries
// (16384 by default) to solid, one per cycle; input stalls, config is taken.
// The output register holds a result while i_out_stall is high; the next
// item is still accepted, and a finished query waits until it can load.
// ----------------------------------------------------------------------------
module voxel_face_visibility #(
    parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_LENGTH = vfv_pkg::CHUNK_LENGTH_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_func,
    input  wire logic [vfv_pkg::X_W-1:0]     i_x_coord,
    input  wire logic [vfv_pkg::Y_W-1:0]     i_y_coord,
    input  wire logic [vfv_pkg::Z_W-1:0]     i_z_coord,
    input  wire logic                        i_is_air,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [vfv_pkg::MASK_W-1:0]       o_face_mask,
    output logic                             o_self_air,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [vfv_pkg::SUPP_W-1:0]  i_cfg_data
);

    localparam int DEPTH = CHUNK_WIDTH * CHUNK_LENGTH * CHUNK_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] OFF_Y    = AW'(1);
    localparam logic [AW-1:0] OFF_Z    = AW'(CHUNK_HEIGHT);
    localparam logic [AW-1:0] OFF_X    = AW'(CHUNK_LENGTH * CHUNK_HEIGHT);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
    localparam logic [2:0]    LAST_STEP = 3'd7;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_SPARE  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [2:0]                 r_step, n_step;
    logic [AW-1:0]              r_base, n_base;
    logic [5:0]                 r_nbr_in, n_nbr_in;
    logic [6:0]                 r_rd, n_rd;
    logic                       r_outside, n_outside;
    logic [AW-1:0]              r_clr_addr, n_clr_addr;
    logic [vfv_pkg::SUPP_W-1:0] r_supp;
    logic                       r_out_valid, n_out_valid;
    logic [vfv_pkg::MASK_W-1:0] r_face_mask, n_face_mask;
    logic                       r_self_air, n_self_air;

    logic                       in_acc, out_free, in_chunk;
    logic [AW-1:0]              in_addr;
    logic [5:0]                 in_nbr;
    logic                       ram_en, ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]              ram_addr;
    logic [vfv_pkg::MASK_W-1:0] mask;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_face_mask = r_face_mask;
    assign o_self_air  = r_self_air;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign in_chunk = (32'(i_x_coord) < 32'(CHUNK_WIDTH)) &&
                      (32'(i_y_coord) < 32'(CHUNK_HEIGHT)) &&
                      (32'(i_z_coord) < 32'(CHUNK_LENGTH));

    assign in_addr = AW'(i_x_coord) * OFF_X + AW'(i_z_coord) * OFF_Z + AW'(i_y_coord);

    // neighbour lies inside the chunk, per face
    assign in_nbr[vfv_pkg::FACE_FRONT]  = 32'(i_z_coord) != 32'(CHUNK_LENGTH - 1);
    assign in_nbr[vfv_pkg::FACE_BACK]   = i_z_coord != '0;
    assign in_nbr[vfv_pkg::FACE_RIGHT]  = 32'(i_x_coord) != 32'(CHUNK_WIDTH - 1);
    assign in_nbr[vfv_pkg::FACE_LEFT]   = i_x_coord != '0;
    assign in_nbr[vfv_pkg::FACE_TOP]    = 32'(i_y_coord) != 32'(CHUNK_HEIGHT - 1);
    assign in_nbr[vfv_pkg::FACE_BOTTOM] = i_y_coord != '0;

    // outside neighbour: open unless that side is suppressed (top never is)
    always_comb begin
        mask[vfv_pkg::FACE_FRONT]  = r_nbr_in[vfv_pkg::FACE_FRONT] ?
            r_rd[vfv_pkg::FACE_FRONT + 1] : !r_supp[vfv_pkg::SUPP_FRONT];
        mask[vfv_pkg::FACE_BACK]   = r_nbr_in[vfv_pkg::FACE_BACK] ?
            r_rd[vfv_pkg::FACE_BACK + 1] : !r_supp[vfv_pkg::SUPP_BACK];
        mask[vfv_pkg::FACE_RIGHT]  = r_nbr_in[vfv_pkg::FACE_RIGHT] ?
            r_rd[vfv_pkg::FACE_RIGHT + 1] : !r_supp[vfv_pkg::SUPP_RIGHT];
        mask[vfv_pkg::FACE_LEFT]   = r_nbr_in[vfv_pkg::FACE_LEFT] ?
            r_rd[vfv_pkg::FACE_LEFT + 1] : !r_supp[vfv_pkg::SUPP_LEFT];
        mask[vfv_pkg::FACE_TOP]    = r_nbr_in[vfv_pkg::FACE_TOP] ?
            r_rd[vfv_pkg::FACE_TOP + 1] : 1'b1;
        mask[vfv_pkg::FACE_BOTTOM] = r_nbr_in[vfv_pkg::FACE_BOTTOM] ?
            r_rd[vfv_pkg::FACE_BOTTOM + 1] : !r_supp[vfv_pkg::SUPP_BOTTOM];
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_base      = r_base;
        n_nbr_in    = r_nbr_in;
        n_rd        = r_rd;
        n_outside   = r_outside;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_face_mask = r_face_mask;
        n_self_air  = r_self_air;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_base;
        ram_wdata   = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == vfv_pkg::FUNC_WRITE) begin
                        ram_en    = in_chunk;
                        ram_we    = 1'b1;
                        ram_addr  = in_addr;
                        ram_wdata = i_is_air;
                    end else begin
                        n_base    = in_addr;
                        n_nbr_in  = in_nbr;
                        n_outside = !in_chunk;
                        n_step    = '0;
                        n_state   = in_chunk ? ST_READ : ST_FINISH;
                    end
                end
            end
            ST_READ: begin
                case (r_step)
                    3'd0: begin ram_en = 1'b1;        ram_addr = r_base;         end
                    3'd1: begin ram_en = r_nbr_in[0]; ram_addr = r_base + OFF_Z; end
                    3'd2: begin ram_en = r_nbr_in[1]; ram_addr = r_base - OFF_Z; end
                    3'd3: begin ram_en = r_nbr_in[2]; ram_addr = r_base + OFF_X; end
                    3'd4: begin ram_en = r_nbr_in[3]; ram_addr = r_base - OFF_X; end
                    3'd5: begin ram_en = r_nbr_in[4]; ram_addr = r_base + OFF_Y; end
                    3'd6: begin ram_en = r_nbr_in[5]; ram_addr = r_base - OFF_Y; end
                    default: begin ram_en = 1'b0; end
                endcase
                if (r_step != '0) begin
                    n_rd[r_step - 3'd1] = ram_rdata;
                end
                n_step = r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_face_mask = r_outside ? '0 : mask;
                    n_self_air  = r_outside ? 1'b0 : r_rd[0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_supp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_supp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_base      <= n_base;
        r_nbr_in    <= n_nbr_in;
        r_rd        <= n_rd;
        r_outside   <= n_outside;
        r_face_mask <= n_face_mask;
        r_self_air  <= n_self_air;
    end

    vfv_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_air_map (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && r_step == LAST_STEP) |=> (r_state == ST_FINISH))
        else $error("query read sequence did not finish");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == vfv_pkg::FUNC_WRITE) |=> (r_state == ST_IDLE))
        else $error("write left the idle state");

    a_outside_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == vfv_pkg::FUNC_QUERY && !in_chunk) |=> (r_state == ST_FINISH))
        else $error("outside query went to the read sequence");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished query not loaded into output");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !ram_we)
        else $error("RAM write during query read");

endmodule
`default_nettype wire
